// File: rtl/indexed_list_store_unit_macros.svh
// assertion macros for the list store rtl, included by indexed_list_store_unit.sv
`ifndef INDEXED_LIST_STORE_UNIT_MACROS_SVH
`define INDEXED_LIST_STORE_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ILS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ils check failed");

// next-cycle implication, checked out of reset
`define ILS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ils check failed");

`endif

// File: rtl/ils_pkg.sv
// ----------------------------------------------------------------------------
// ils_pkg
// shared codes, widths and the per-cell control bundle of the list store
// ----------------------------------------------------------------------------
package ils_pkg;

    localparam int DATA_W = 64;
    localparam int FUNC_W = 3;
    localparam int IDX_W  = 7;
    localparam int LEN_W  = 7;
    // wide enough for any position up to the largest supported capacity
    localparam int POS_W  = 11;

    typedef enum logic [FUNC_W-1:0] {
        OP_APPEND   = 3'd0,
        OP_READ     = 3'd1,
        OP_WRITE    = 3'd2,
        OP_INSERT   = 3'd3,
        OP_REMOVE   = 3'd4,
        OP_CLEAR    = 3'd5,
        OP_CONTAINS = 3'd6
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef struct packed {
        logic              wr_en;
        logic              ins_en;
        logic              rem_en;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  len;
        logic [DATA_W-1:0] value;
    } cell_ctrl_t;

endpackage

// File: rtl/ils_cell.sv
// ----------------------------------------------------------------------------
// ils_cell
// one list slot: holds a word, shifts with its neighbors, reads and matches
// ----------------------------------------------------------------------------
module ils_cell
    import ils_pkg::*;
(
    input  logic              clk,
    input  cell_ctrl_t        ctrl,
    input  logic [POS_W-1:0]  pos,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [DATA_W-1:0] next_data,
    output logic [DATA_W-1:0] data,
    output logic [DATA_W-1:0] rd_part,
    output logic              hit
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              at_target;
    logic              above_target;

    assign at_target    = (pos == ctrl.target);
    assign above_target = (pos > ctrl.target);

    always_comb
    begin
        data_next = data_reg;
        priority if (ctrl.ins_en)
        begin
            if (above_target)
            begin
                data_next = prev_data;
            end
            else if (at_target)
            begin
                data_next = ctrl.value;
            end
        end
        else if (ctrl.rem_en)
        begin
            if (at_target || above_target)
            begin
                data_next = next_data;
            end
        end
        else if (ctrl.wr_en)
        begin
            if (at_target)
            begin
                data_next = ctrl.value;
            end
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_part = at_target ? data_reg : '0;
    // only slots inside the live list take part in the search
    assign hit     = (pos < ctrl.len) && (data_reg == ctrl.value);

endmodule

// File: rtl/indexed_list_store_unit.sv
// ----------------------------------------------------------------------------
// indexed_list_store_unit
// fixed-capacity ordered list of 64-bit words built as a row of shift cells
// ----------------------------------------------------------------------------
// usage:
//   a request (func, index, value) is taken at a rising edge with start high
//   and busy low; busy stays low, so a request may come every cycle
//   the result (read_value, found, status, list_length) is shown for one
//   cycle with done high, in the cycle after the request edge
//   throughput 1 request per cycle: every slot is a cell that shifts toward
//   its neighbor, loads, reads and compares in the same cycle, so insert,
//   remove and contains touch all slots at once
//   the read and search paths end in an or-tree across all cells
//   reset clears the internal length count to zero and drops done; slot contents are left
//   undefined and are never seen, since only slots below the length count
//   the receiver cannot stall: a result not taken in its cycle is gone
// ----------------------------------------------------------------------------
`include "indexed_list_store_unit_macros.svh"

module indexed_list_store_unit
    import ils_pkg::*;
#(
    parameter int CAPACITY = 64
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [FUNC_W-1:0] func,
    input  logic [IDX_W-1:0]  index,
    input  logic [DATA_W-1:0] value,
    output logic              done,
    output logic [DATA_W-1:0] read_value,
    output logic              found,
    output logic [1:0]        status,
    output logic [LEN_W-1:0]  list_length
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              done_reg;
    logic [DATA_W-1:0] read_value_reg;
    logic [DATA_W-1:0] read_value_next;
    logic              found_reg;
    logic              found_next;
    status_t           status_reg;
    status_t           status_next;
    logic [LEN_W-1:0]  length_reg;

    cell_ctrl_t        ctrl;
    logic [CMP_W-1:0]  idx_w;
    logic [CMP_W-1:0]  cnt_w;
    logic              full;
    logic              go;
    op_t               op;

    logic [DATA_W-1:0] cell_data [CAPACITY];
    logic [DATA_W-1:0] cell_rd   [CAPACITY];
    logic [CAPACITY-1:0] cell_hit;
    logic [DATA_W-1:0] rd_any;

    assign busy  = 1'b0;
    assign go    = start && !busy;
    assign op    = op_t'(func);
    assign idx_w = CMP_W'(index);
    assign cnt_w = CMP_W'(cnt_reg);
    assign full  = (cnt_reg == CNT_W'(CAPACITY));

    // decode the request into cell controls, the status and the next length
    always_comb
    begin
        ctrl.wr_en  = 1'b0;
        ctrl.ins_en = 1'b0;
        ctrl.rem_en = 1'b0;
        ctrl.target = POS_W'(index);
        ctrl.len    = POS_W'(cnt_reg);
        ctrl.value  = value;
        cnt_next    = cnt_reg;
        status_next = ST_OK;
        if (go)
        begin
            unique case (op)
                OP_APPEND, OP_WRITE:
                begin
                    if (op == OP_WRITE && idx_w < cnt_w)
                    begin
                        ctrl.wr_en = 1'b1;
                    end
                    else if (op == OP_WRITE && idx_w > cnt_w)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.wr_en  = 1'b1;
                        ctrl.target = POS_W'(cnt_reg);
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (idx_w >= cnt_w)
                    begin
                        status_next = ST_RANGE;
                    end
                end
                OP_INSERT:
                begin
                    if (idx_w > cnt_w)
                    begin
                        status_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        ctrl.ins_en = 1'b1;
                        cnt_next    = cnt_reg + 1'b1;
                    end
                end
                OP_REMOVE:
                begin
                    if (idx_w >= cnt_w)
                    begin
                        status_next = ST_RANGE;
                    end
                    else
                    begin
                        ctrl.rem_en = 1'b1;
                        cnt_next    = cnt_reg - 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    cnt_next = '0;
                end
                OP_CONTAINS:
                begin
                end
                default:
                begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [DATA_W-1:0] prev_d;
            logic [DATA_W-1:0] next_d;
            if (g == 0)
            begin : g_first
                assign prev_d = '0;
            end
            else
            begin : g_mid_lo
                assign prev_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_d = cell_data[g];
            end
            else
            begin : g_mid_hi
                assign next_d = cell_data[g+1];
            end
            ils_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .pos       (POS_W'(g)),
                .prev_data (prev_d),
                .next_data (next_d),
                .data      (cell_data[g]),
                .rd_part   (cell_rd[g]),
                .hit       (cell_hit[g])
            );
        end
    endgenerate

    // at most one cell drives a nonzero read word
    always_comb
    begin
        rd_any = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_any = rd_any | cell_rd[i];
        end
    end

    always_comb
    begin
        read_value_next = '0;
        found_next      = 1'b0;
        if (op == OP_READ && status_next == ST_OK)
        begin
            read_value_next = rd_any;
        end
        if (op == OP_CONTAINS)
        begin
            found_next = |cell_hit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            read_value_reg <= read_value_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
            length_reg     <= LEN_W'(cnt_next);
        end
    end

    assign done        = done_reg;
    assign read_value  = read_value_reg;
    assign found       = found_reg;
    assign status      = status_reg;
    assign list_length = length_reg;

    `ILS_ASSERT_NEXT(a_done_follows_start, start, done)
    `ILS_ASSERT_NEXT(a_no_done_unasked, !start, !done)
    `ILS_ASSERT_NOW(a_count_in_range, 1'b1, cnt_reg <= CNT_W'(CAPACITY))
    `ILS_ASSERT_NOW(a_full_only_at_capacity, done && status == ST_FULL,
        cnt_reg == CNT_W'(CAPACITY))
    `ILS_ASSERT_NEXT(a_clear_empties, start && func == OP_CLEAR, cnt_reg == '0)

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the indexed list store: requests go in one at a time
// under start/busy, a shadow copy of the list predicts every result, and each
// done strobe is compared field by field with the oldest prediction
// ----------------------------------------------------------------------------
module tb_top;

    import ils_pkg::*;

    localparam int LIST_CAPACITY = 64;
    // code 7 has no operation behind it
    localparam logic [FUNC_W-1:0] OP_UNUSED = 3'd7;

    localparam int MODE_GROW   = 0;
    localparam int MODE_SHRINK = 1;
    localparam int MODE_MIXED  = 2;

    // per mode, weights for codes 0..7 (append .. unused), each row sums to 100
    localparam int unsigned OP_WEIGHTS [3][8] = '{
        '{28, 15, 25,  8,  5, 15, 1, 3},
        '{ 5, 15, 10,  5, 45, 15, 2, 3},
        '{15, 15, 15, 15, 18, 14, 5, 3}
    };

    typedef struct packed {
        logic [FUNC_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] read_value;
        logic              found;
        status_t           status;
        logic [LEN_W-1:0]  list_length;
    } list_result_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic [FUNC_W-1:0] func = '0;
    logic [IDX_W-1:0]  index = '0;
    logic [DATA_W-1:0] value = '0;
    logic              done;
    logic [DATA_W-1:0] read_value;
    logic              found;
    logic [1:0]        status;
    logic [LEN_W-1:0]  list_length;

    logic [DATA_W-1:0] shadow_words [LIST_CAPACITY];
    int                shadow_len = 0;
    list_result_t      predicted_results [$];
    int                mismatch_count = 0;
    int                idle_pct = 0;

    indexed_list_store_unit #(
        .CAPACITY(LIST_CAPACITY)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .func(func),
        .index(index),
        .value(value),
        .done(done),
        .read_value(read_value),
        .found(found),
        .status(status),
        .list_length(list_length)
    );

    always #4 clk = ~clk;

    function automatic status_t shadow_push(input logic [DATA_W-1:0] word);
        if (shadow_len >= LIST_CAPACITY)
            return ST_FULL;
        shadow_words[shadow_len] = word;
        shadow_len++;
        return ST_OK;
    endfunction

    function automatic list_result_t predict_list_op(input logic [FUNC_W-1:0] code,
                                                     input logic [IDX_W-1:0] idx,
                                                     input logic [DATA_W-1:0] word);
        list_result_t r;
        int pos;
        int i;
        r.code = code;
        r.idx = idx;
        r.read_value = '0;
        r.found = 1'b0;
        r.status = ST_OK;
        pos = int'(idx);
        case (code)
            OP_APPEND: r.status = shadow_push(word);
            OP_READ:
            begin
                if (pos < shadow_len)
                    r.read_value = shadow_words[pos];
                else
                    r.status = ST_RANGE;
            end
            OP_WRITE:
            begin
                if (pos < shadow_len)
                    shadow_words[pos] = word;
                else if (pos == shadow_len)
                    r.status = shadow_push(word);
                else
                    r.status = ST_RANGE;
            end
            OP_INSERT:
            begin
                // index is checked before fullness
                if (pos > shadow_len)
                    r.status = ST_RANGE;
                else if (shadow_len >= LIST_CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (i = shadow_len; i > pos; i--)
                        shadow_words[i] = shadow_words[i-1];
                    shadow_words[pos] = word;
                    shadow_len++;
                end
            end
            OP_REMOVE:
            begin
                if (pos >= shadow_len)
                    r.status = ST_RANGE;
                else
                begin
                    for (i = pos; i + 1 < shadow_len; i++)
                        shadow_words[i] = shadow_words[i+1];
                    shadow_len--;
                end
            end
            // stored words stay, only the length drops
            OP_CLEAR: shadow_len = 0;
            OP_CONTAINS:
            begin
                for (i = 0; i < shadow_len; i++)
                    if (shadow_words[i] == word)
                        r.found = 1'b1;
            end
            default: ;
        endcase
        r.list_length = shadow_len[LEN_W-1:0];
        return r;
    endfunction

    task automatic pause_sender();
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
    endtask

    // start stays high on return unless the sender pauses, so back-to-back requests need no gap
    task automatic send_request(input logic [FUNC_W-1:0] code,
                                input logic [IDX_W-1:0] idx,
                                input logic [DATA_W-1:0] word);
        start <= 1'b1;
        func <= code;
        index <= idx;
        value <= word;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted_results.push_back(predict_list_op(code, idx, word));
        pause_sender();
    endtask

    always @(posedge clk)
    begin
        list_result_t exp_res;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("result with no request pending: rd %h found %b st %0d len %0d",
                             read_value, found, status, list_length);
            end
            else
            begin
                exp_res = predicted_results.pop_front();
                if (read_value !== exp_res.read_value || found !== exp_res.found ||
                    status !== exp_res.status || list_length !== exp_res.list_length)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $display("mismatch op %0d idx %0d: expected rd %h found %b st %0d len %0d",
                                 exp_res.code, exp_res.idx, exp_res.read_value,
                                 exp_res.found, exp_res.status, exp_res.list_length);
                        $display("    got rd %h found %b st %0d len %0d",
                                 read_value, found, status, list_length);
                    end
                end
            end
        end
    end

    function automatic logic [DATA_W-1:0] random_word();
        logic [DATA_W-1:0] one_hot;
        one_hot = 64'd1 << $urandom_range(0, 63);
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            // small values repeat often, so duplicates and search hits happen
            4, 5: return DATA_W'($urandom_range(0, 7));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [IDX_W-1:0] pick_index();
        case ($urandom_range(0, 9))
            0: return IDX_W'($urandom_range(0, 127));
            1: return IDX_W'(shadow_len);
            2: return IDX_W'(shadow_len + 1);
            3: return '0;
            4: return IDX_W'((shadow_len > 0) ? shadow_len - 1 : 0);
            default: return IDX_W'($urandom_range(0, (shadow_len > 0) ? shadow_len - 1 : 0));
        endcase
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op(input int mode);
        int unsigned roll;
        int unsigned acc;
        int c;
        roll = $urandom_range(0, 99);
        acc = 0;
        for (c = 0; c < 8; c++)
        begin
            acc += OP_WEIGHTS[mode][c];
            if (roll < acc)
                return FUNC_W'(c);
        end
        return OP_UNUSED;
    endfunction

    task automatic test_empty_list();
        send_request(OP_READ, 7'd0, '0);
        send_request(OP_REMOVE, 7'd0, '0);
        send_request(OP_WRITE, 7'd1, '1);
        send_request(OP_INSERT, 7'd1, '1);
        send_request(OP_CONTAINS, 7'd0, '0);
        send_request(OP_UNUSED, 7'd127, '1);
    endtask

    task automatic test_basic_ops();
        send_request(OP_APPEND, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_APPEND, 7'd0, 64'h0);
        // write at the length appends
        send_request(OP_WRITE, 7'd2, 64'h8000_0000_0000_0000);
        send_request(OP_WRITE, 7'd4, 64'h1111_2222_3333_4444);
        send_request(OP_WRITE, 7'd1, 64'h0123_4567_89AB_CDEF);
        send_request(OP_INSERT, 7'd0, 64'h0000_0000_0000_0001);
        send_request(OP_INSERT, 7'd2, 64'hDEAD_BEEF_0000_5555);
        send_request(OP_INSERT, 7'd5, 64'h7FFF_FFFF_FFFF_FFFF);
        send_request(OP_INSERT, 7'd7, 64'h2);
        send_request(OP_READ, 7'd127, '0);
        send_request(OP_REMOVE, 7'd0, '0);
        send_request(OP_REMOVE, 7'd4, '0);
        send_request(OP_REMOVE, 7'd127, '0);
        send_request(OP_CONTAINS, 7'd0, 64'h8000_0000_0000_0000);
        send_request(OP_CONTAINS, 7'd0, 64'h5555);
        send_request(OP_CLEAR, 7'd3, '1);
        // words left behind by a clear must not be found
        send_request(OP_CONTAINS, 7'd0, 64'hFFFF_FFFF_FFFF_FFFF);
        send_request(OP_READ, 7'd0, '0);
        send_request(OP_WRITE, 7'd0, 64'h5A5A_A5A5_5A5A_A5A5);
        send_request(OP_READ, 7'd0, '0);
    endtask

    task automatic test_full_list();
        logic [DATA_W-1:0] word;
        send_request(OP_CLEAR, 7'd0, '0);
        while (shadow_len < LIST_CAPACITY)
        begin
            word = random_word();
            case ($urandom_range(0, 2))
                0: send_request(OP_APPEND, IDX_W'($urandom_range(0, 127)), word);
                1: send_request(OP_WRITE, IDX_W'(shadow_len), word);
                default: send_request(OP_INSERT, IDX_W'($urandom_range(0, shadow_len)), word);
            endcase
        end
        send_request(OP_APPEND, 7'd0, random_word());
        send_request(OP_WRITE, 7'd64, random_word());
        send_request(OP_INSERT, 7'd64, random_word());
        send_request(OP_INSERT, 7'd0, random_word());
        send_request(OP_INSERT, 7'd65, random_word());
        send_request(OP_WRITE, 7'd63, random_word());
        send_request(OP_READ, 7'd63, '0);
        send_request(OP_CONTAINS, 7'd0, shadow_words[LIST_CAPACITY-1]);
        send_request(OP_REMOVE, 7'd64, '0);
        send_request(OP_REMOVE, 7'd0, '0);
        send_request(OP_INSERT, 7'd63, random_word());
        send_request(OP_READ, 7'd0, '0);
        send_request(OP_CLEAR, 7'd0, '0);
    endtask

    task automatic test_random_ops(input int num_items, input bit with_idle);
        int n;
        int left_in_phase;
        int mode;
        logic [FUNC_W-1:0] code;
        logic [DATA_W-1:0] word;
        left_in_phase = 0;
        mode = MODE_MIXED;
        for (n = 0; n < num_items; n++)
        begin
            if (left_in_phase == 0)
            begin
                left_in_phase = $urandom_range(20, 60);
                mode = $urandom_range(MODE_GROW, MODE_MIXED);
                case ($urandom_range(0, 2))
                    0: idle_pct = 0;
                    1: idle_pct = with_idle ? 8 : 0;
                    default: idle_pct = with_idle ? 25 : 0;
                endcase
            end
            left_in_phase--;
            code = pick_op(mode);
            if (code == OP_CONTAINS && shadow_len > 0 && $urandom_range(0, 1) == 1)
                word = shadow_words[$urandom_range(0, shadow_len - 1)];
            else
                word = random_word();
            send_request(code, pick_index(), word);
        end
    endtask

    initial
    begin
        #3_000_000;
        $display("indexed_list_store_unit verification failed");
        $finish;
    end

    initial
    begin
        int guard;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        idle_pct = 20;
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_random_ops(500, 1'b1);
        // closing stretch runs back to back
        test_random_ops(150, 1'b0);
        start <= 1'b0;
        guard = 0;
        while (predicted_results.size() != 0 && guard < 64)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (4) @(posedge clk);
        if (mismatch_count == 0 && predicted_results.size() == 0)
            $display("indexed_list_store_unit verification clean");
        else
            $display("indexed_list_store_unit verification failed");
        $finish;
    end

endmodule
